// File: design/lsmr_pkg.sv
// Shared types, constants and angle helpers for the lidar sector minimum range block.
`timescale 1ns / 1ps
`default_nettype none
package lsmr_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] CFG_MIN_RANGE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_RANGE  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_ANG  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ANG_STEP   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FRONT_HALF = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SIDE_HALF  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_REAR_HALF  = 3'd6;

  localparam logic signed [18:0] HALF_TURN     = 19'sd18000;
  localparam logic signed [18:0] NEG_HALF_TURN = -19'sd18000;
  localparam logic signed [18:0] FULL_TURN     = 19'sd36000;
  localparam logic signed [18:0] TURN_AND_HALF = 19'sd54000;
  localparam logic signed [18:0] NEG_TURN_HALF = -19'sd54000;
  localparam logic signed [18:0] TWO_TURNS     = 19'sd72000;

  localparam logic signed [18:0] CTR_FRONT = 19'sd0;
  localparam logic signed [18:0] CTR_LEFT  = 19'sd9000;
  localparam logic signed [18:0] CTR_RIGHT = -19'sd9000;
  localparam logic signed [18:0] CTR_REAR  = 19'sd18000;

  localparam int unsigned NumSectors = 4;

  typedef logic signed [15:0] angle_t;

  typedef struct packed {
    logic [15:0] range_mm;
    logic        range_finite;
    logic        last_in_scan;
  } sample_t;

  typedef struct packed {
    logic [12:0] point_count;
    logic [12:0] pass_count;
    logic [15:0] front_near_mm;
    logic        front_found;
    logic [15:0] left_near_mm;
    logic        left_found;
    logic [15:0] right_near_mm;
    logic        right_found;
    logic [15:0] rear_near_mm;
    logic        rear_found;
    logic [15:0] nearest_range;
    angle_t      nearest_angle;
  } summary_t;

  typedef struct packed {
    logic [15:0] min_range_mm;
    logic [15:0] max_range_mm;
    logic [14:0] front_half_width;
    logic [14:0] side_half_width;
    logic [14:0] rear_half_width;
  } filt_cfg_t;

  // Wrap into [-18000,18000); valid for inputs within two turns of the window.
  function automatic angle_t wrap_angle(input logic signed [18:0] v);
    logic signed [18:0] r;
    if (v < NEG_TURN_HALF) begin
      r = v + TWO_TURNS;
    end else if (v < NEG_HALF_TURN) begin
      r = v + FULL_TURN;
    end else if (v < HALF_TURN) begin
      r = v;
    end else if (v < TURN_AND_HALF) begin
      r = v - FULL_TURN;
    end else begin
      r = v - TWO_TURNS;
    end
    return angle_t'(r[15:0]);
  endfunction

  function automatic logic in_sector(input angle_t ang, input logic signed [18:0] ctr,
                                     input logic [14:0] half);
    logic signed [18:0] diff;
    angle_t             d;
    logic [16:0]        mag;
    diff = {{3{ang[15]}}, ang} - ctr;
    d    = wrap_angle(diff);
    mag  = d[15] ? (17'd0 - {d[15], d}) : {1'b0, d};
    return mag <= {2'b00, half};
  endfunction

endpackage
`default_nettype wire

// File: design/lsmr_angle_gen.sv
// Running sample angle tracker: hands out the angle of each accepted sample.
`timescale 1ns / 1ps
`default_nettype none
module lsmr_angle_gen (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic               last_i,
  input  wire logic signed [15:0] start_angle_i,
  input  wire logic signed [16:0] angle_step_i,
  output lsmr_pkg::angle_t        angle_o
);
  import lsmr_pkg::*;

  logic   first_q, first_d;
  angle_t cur_q, cur_d;
  angle_t start_wrapped;

  always_comb begin
    start_wrapped = wrap_angle({{3{start_angle_i[15]}}, start_angle_i});
    angle_o       = first_q ? start_wrapped : cur_q;
    cur_d         = wrap_angle({{3{angle_o[15]}}, angle_o} +
                               {{2{angle_step_i[16]}}, angle_step_i});
    first_d       = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      cur_q   <= '0;
    end else if (accept_i) begin
      first_q <= first_d;
      cur_q   <= cur_d;
    end
  end

endmodule
`default_nettype wire

// File: design/lsmr_scan_acc.sv
// Per-scan accumulator: counters, nearest sample and sector minima.
`timescale 1ns / 1ps
`default_nettype none
module lsmr_scan_acc #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire lsmr_pkg::sample_t  sample_i,
  input  wire lsmr_pkg::angle_t   angle_i,
  input  wire lsmr_pkg::filt_cfg_t cfg_i,
  output lsmr_pkg::summary_t      summary_o
);
  import lsmr_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_POINTS);

  logic [CntW-1:0]       seen_q, seen_d, vcnt_q, vcnt_d;
  logic                  any_q, any_d;
  logic [15:0]           near_q, near_d;
  angle_t                near_ang_q, near_ang_d;
  logic [NumSectors-1:0] hit_q, hit_d, in_sec;
  logic [15:0]           smin_q [NumSectors];
  logic [15:0]           smin_d [NumSectors];
  logic                  ok;
  logic [CntW+12:0]      seen_ext, vcnt_ext;

  always_comb begin
    ok = sample_i.range_finite && (sample_i.range_mm >= cfg_i.min_range_mm) &&
         (sample_i.range_mm <= cfg_i.max_range_mm);
    in_sec[0] = in_sector(angle_i, CTR_FRONT, cfg_i.front_half_width);
    in_sec[1] = in_sector(angle_i, CTR_LEFT, cfg_i.side_half_width);
    in_sec[2] = in_sector(angle_i, CTR_RIGHT, cfg_i.side_half_width);
    in_sec[3] = in_sector(angle_i, CTR_REAR, cfg_i.rear_half_width);

    seen_d     = (seen_q == CntMax) ? seen_q : seen_q + 1'b1;
    vcnt_d     = vcnt_q;
    any_d      = any_q;
    near_d     = near_q;
    near_ang_d = near_ang_q;
    hit_d      = hit_q;
    for (int k = 0; k < NumSectors; k++) begin
      smin_d[k] = smin_q[k];
    end
    if (ok) begin
      any_d = 1'b1;
      if (vcnt_q != CntMax) begin
        vcnt_d = vcnt_q + 1'b1;
      end
      if (!any_q || sample_i.range_mm < near_q) begin
        near_d     = sample_i.range_mm;
        near_ang_d = angle_i;
      end
      for (int k = 0; k < NumSectors; k++) begin
        if (in_sec[k] && (!hit_q[k] || sample_i.range_mm < smin_q[k])) begin
          smin_d[k] = sample_i.range_mm;
          hit_d[k]  = 1'b1;
        end
      end
    end

    seen_ext = {13'd0, seen_d};
    vcnt_ext = {13'd0, vcnt_d};
    summary_o.point_count   = seen_ext[12:0];
    summary_o.pass_count    = vcnt_ext[12:0];
    summary_o.front_near_mm = smin_d[0];
    summary_o.front_found   = hit_d[0];
    summary_o.left_near_mm  = smin_d[1];
    summary_o.left_found    = hit_d[1];
    summary_o.right_near_mm = smin_d[2];
    summary_o.right_found   = hit_d[2];
    summary_o.rear_near_mm  = smin_d[3];
    summary_o.rear_found    = hit_d[3];
    summary_o.nearest_range = near_d;
    summary_o.nearest_angle = near_ang_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      vcnt_q     <= '0;
      any_q      <= 1'b0;
      near_q     <= '1;
      near_ang_q <= '0;
      hit_q      <= '0;
      for (int k = 0; k < NumSectors; k++) begin
        smin_q[k] <= '1;
      end
    end else if (adv_i) begin
      if (sample_i.last_in_scan) begin
        seen_q     <= '0;
        vcnt_q     <= '0;
        any_q      <= 1'b0;
        near_q     <= '1;
        near_ang_q <= '0;
        hit_q      <= '0;
        for (int k = 0; k < NumSectors; k++) begin
          smin_q[k] <= '1;
        end
      end else begin
        seen_q     <= seen_d;
        vcnt_q     <= vcnt_d;
        any_q      <= any_d;
        near_q     <= near_d;
        near_ang_q <= near_ang_d;
        hit_q      <= hit_d;
        for (int k = 0; k < NumSectors; k++) begin
          smin_q[k] <= smin_d[k];
        end
      end
    end
  end

  a_vcnt_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= seen_q) else $error("valid count above point count");

  a_any_matches_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q == (vcnt_q != '0)) else $error("valid flag disagrees with count");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && sample_i.last_in_scan |=> seen_q == '0 && hit_q == '0 && !any_q)
    else $error("scan state not cleared after last sample");

  a_hit_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q != '0 |-> any_q) else $error("sector hit without a valid sample");

endmodule
`default_nettype wire

// File: design/lidar_sector_min_range_core.sv
// Top level of the lidar sector minimum range block.
// Usage:
//   Range samples arrive on the in_* valid/ready channel, one per transaction.
//   The sample marked last_in_scan closes the scan: one summary transaction is
//   then presented on out_* (valid/ready). Other samples produce no output.
//   Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i, one per
//   cycle, while no transaction is in flight; indexes 7 and above are ignored.
// Timing:
//   One sample per cycle is accepted while in_ready_o is high. A sample is
//   captured in an input register and folded into the scan state from there;
//   a closing sample loads its summary into the output register, which drives
//   out_valid_o, at the same edge at which it is folded in.
//   While a summary waits for out_ready_i, further samples keep flowing into
//   the next scan; only a following last sample waits in the input register,
//   which then holds off in_ready_o.
// Reset:
//   Asynchronous active-low reset clears the scan state, loads the register
//   defaults and empties both the input and output registers.
`timescale 1ns / 1ps
`default_nettype none
module lidar_sector_min_range_core #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire lsmr_pkg::sample_t                in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output lsmr_pkg::summary_t                    out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [lsmr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [lsmr_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import lsmr_pkg::*;

  filt_cfg_t          cfg_q;
  logic signed [15:0] start_q;
  logic signed [16:0] step_q;

  logic     s1_valid_q, s1_valid_d;
  sample_t  s1_q;
  angle_t   s1_ang_q;
  angle_t   new_ang;
  logic     in_acc, s1_adv, out_free;
  logic     out_valid_q, out_valid_d;
  summary_t out_q, acc_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_range_mm     <= 16'd100;
      cfg_q.max_range_mm     <= 16'd12000;
      cfg_q.front_half_width <= 15'd1500;
      cfg_q.side_half_width  <= 15'd2000;
      cfg_q.rear_half_width  <= 15'd2000;
      start_q                <= -16'sd18000;
      step_q                 <= 17'sd50;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_RANGE:  cfg_q.min_range_mm     <= cfg_wdata_i[15:0];
        CFG_MAX_RANGE:  cfg_q.max_range_mm     <= cfg_wdata_i[15:0];
        CFG_START_ANG:  start_q                <= signed'(cfg_wdata_i[15:0]);
        CFG_ANG_STEP:   step_q                 <= signed'(cfg_wdata_i);
        CFG_FRONT_HALF: cfg_q.front_half_width <= cfg_wdata_i[14:0];
        CFG_SIDE_HALF:  cfg_q.side_half_width  <= cfg_wdata_i[14:0];
        CFG_REAR_HALF:  cfg_q.rear_half_width  <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    s1_adv      = s1_valid_q && (!s1_q.last_in_scan || out_free);
    in_ready_o  = !s1_valid_q || s1_adv;
    in_acc      = in_valid_i && in_ready_o;
    s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = (s1_adv && s1_q.last_in_scan) ? 1'b1 :
                  (out_ready_i ? 1'b0 : out_valid_q);
    out_valid_o = out_valid_q;
    out_data_o  = out_q;
  end

  lsmr_angle_gen u_angle (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .last_i        (in_data_i.last_in_scan),
    .start_angle_i (start_q),
    .angle_step_i  (step_q),
    .angle_o       (new_ang)
  );

  lsmr_scan_acc #(
    .MAX_POINTS (MAX_POINTS)
  ) u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (s1_adv),
    .sample_i  (s1_q),
    .angle_i   (s1_ang_q),
    .cfg_i     (cfg_q),
    .summary_o (acc_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q     <= in_data_i;
      s1_ang_q <= new_ang;
    end
    if (s1_adv && s1_q.last_in_scan) begin
      out_q <= acc_sum;
    end
  end

  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_q.last_in_scan && !out_free |=> s1_valid_q && $stable(s1_q))
    else $error("stalled last sample dropped");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("pending summary overwritten");

  a_nonlast_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_q.last_in_scan |-> in_ready_o)
    else $error("ordinary sample stalled the input");

endmodule
`default_nettype wire

// File: tb/lidar_sector_min_range_core_tb.sv
// Self-checking testbench for the lidar sector minimum range core.
`timescale 1ns / 1ps
module lidar_sector_min_range_core_tb;
  import lsmr_pkg::*;

  localparam int MaxPoints = 4096;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;

  // Summary of a one-sample scan whose sample is rejected.
  localparam summary_t LONE_INVALID = '{
    point_count: 13'd1, pass_count: 13'd0,
    front_near_mm: 16'hFFFF, front_found: 1'b0,
    left_near_mm: 16'hFFFF, left_found: 1'b0,
    right_near_mm: 16'hFFFF, right_found: 1'b0,
    rear_near_mm: 16'hFFFF, rear_found: 1'b0,
    nearest_range: 16'hFFFF, nearest_angle: 16'sd0
  };

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_e;

  typedef struct {
    row_e                kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    sample_t             smp;
    bit                  lit;
  } plan_row_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  sample_t             in_data   = '0;
  logic                out_ready = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  wire                 in_ready;
  wire                 out_valid;
  summary_t            out_data;

  lidar_sector_min_range_core #(
    .MAX_POINTS(MaxPoints)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Register image
  int lo_mm, hi_mm, start_cd, step_cd, hw_front, hw_side, hw_rear;
  // Scan state
  int heading_cd, n_seen, n_valid, near_mm, near_cd;
  int sec_min[4];
  bit sec_hit[4];

  summary_t  pending_summaries[$];
  plan_row_t plan[$];
  int        n_errors = 0;
  int        n_scans  = 0;
  int        src_idle_pct = 33;
  int        snk_idle_pct = 69;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(64'd5_000_000);
    $display("FAIL lidar_sector_min_range_core");
    $finish;
  end

  function automatic int fold_turn(input int v);
    int r;
    r = (v + int'(HALF_TURN)) % int'(FULL_TURN);
    if (r < 0) r += int'(FULL_TURN);
    return r - int'(HALF_TURN);
  endfunction

  function automatic bit covers(input int ang, input int ctr, input int half);
    int d;
    d = fold_turn(ang - ctr);
    if (d < 0) d = -d;
    return d <= half;
  endfunction

  function automatic void clear_scan();
    heading_cd = fold_turn(start_cd);
    n_seen     = 0;
    n_valid    = 0;
    for (int k = 0; k < 4; k++) begin
      sec_min[k] = 'hFFFF;
      sec_hit[k] = 1'b0;
    end
    near_mm = 'hFFFF;
    near_cd = 0;
  endfunction

  function automatic void set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] v);
    case (idx)
      CFG_MIN_RANGE:  lo_mm    = int'(v[15:0]);
      CFG_MAX_RANGE:  hi_mm    = int'(v[15:0]);
      CFG_START_ANG:  start_cd = int'($signed(v[15:0]));
      CFG_ANG_STEP:   step_cd  = int'($signed(v[16:0]));
      CFG_FRONT_HALF: hw_front = int'(v[14:0]);
      CFG_SIDE_HALF:  hw_side  = int'(v[14:0]);
      CFG_REAR_HALF:  hw_rear  = int'(v[14:0]);
      default: ;
    endcase
  endfunction

  function automatic void absorb(input int k, input int r);
    if (!sec_hit[k] || r < sec_min[k]) begin
      sec_min[k] = r;
      sec_hit[k] = 1'b1;
    end
  endfunction

  // Folds one sample into the scan; returns 1 with the summary on the closing sample.
  function automatic bit fold_sample(input sample_t s, output summary_t res);
    int ang;
    int r;
    r   = int'(s.range_mm);
    ang = (n_seen == 0) ? fold_turn(start_cd) : heading_cd;
    res = '0;
    if (s.range_finite && r >= lo_mm && r <= hi_mm) begin
      if (n_valid == 0 || r < near_mm) begin
        near_mm = r;
        near_cd = ang;
      end
      if (n_valid < MaxPoints) n_valid++;
      if (covers(ang, int'(CTR_FRONT), hw_front)) absorb(0, r);
      if (covers(ang, int'(CTR_LEFT), hw_side)) absorb(1, r);
      if (covers(ang, int'(CTR_RIGHT), hw_side)) absorb(2, r);
      if (covers(ang, int'(CTR_REAR), hw_rear)) absorb(3, r);
    end
    if (n_seen < MaxPoints) n_seen++;
    heading_cd = fold_turn(ang + step_cd);
    if (!s.last_in_scan) return 1'b0;
    res.point_count   = 13'(n_seen);
    res.pass_count    = 13'(n_valid);
    res.front_near_mm = sec_hit[0] ? 16'(sec_min[0]) : 16'hFFFF;
    res.front_found   = sec_hit[0];
    res.left_near_mm  = sec_hit[1] ? 16'(sec_min[1]) : 16'hFFFF;
    res.left_found    = sec_hit[1];
    res.right_near_mm = sec_hit[2] ? 16'(sec_min[2]) : 16'hFFFF;
    res.right_found   = sec_hit[2];
    res.rear_near_mm  = sec_hit[3] ? 16'(sec_min[3]) : 16'hFFFF;
    res.rear_found    = sec_hit[3];
    res.nearest_range = (n_valid != 0) ? 16'(near_mm) : 16'hFFFF;
    res.nearest_angle = (n_valid != 0) ? angle_t'(16'(near_cd)) : angle_t'(0);
    clear_scan();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("summary %0d %s got %0h want %0h", n_scans, name, got, want));
  endtask

  task automatic check_summary(input summary_t got, input summary_t want);
    check_field("point_count", 32'(got.point_count), 32'(want.point_count));
    check_field("pass_count", 32'(got.pass_count), 32'(want.pass_count));
    check_field("front_near_mm", 32'(got.front_near_mm), 32'(want.front_near_mm));
    check_field("front_found", 32'(got.front_found), 32'(want.front_found));
    check_field("left_near_mm", 32'(got.left_near_mm), 32'(want.left_near_mm));
    check_field("left_found", 32'(got.left_found), 32'(want.left_found));
    check_field("right_near_mm", 32'(got.right_near_mm), 32'(want.right_near_mm));
    check_field("right_found", 32'(got.right_found), 32'(want.right_found));
    check_field("rear_near_mm", 32'(got.rear_near_mm), 32'(want.rear_near_mm));
    check_field("rear_found", 32'(got.rear_found), 32'(want.rear_found));
    check_field("nearest_range", 32'(got.nearest_range), 32'(want.nearest_range));
    check_field("nearest_angle", 32'(got.nearest_angle), 32'(want.nearest_angle));
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin : summary_monitor
    summary_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_summaries.size() == 0) begin
        report_mismatch("summary transaction with no scan closed");
      end else begin
        want = pending_summaries.pop_front();
        check_summary(out_data, want);
      end
      n_scans++;
    end
  end

  task automatic deliver(input sample_t s, input bit lit, input summary_t want);
    summary_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    if (fold_sample(s, res)) pending_summaries.push_back(lit ? want : res);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    set_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic plan_row_t smp(input logic [15:0] r, input bit fin, input bit last,
                                    input bit lit);
    plan_row_t row;
    row.kind = ROW_SAMPLE;
    row.idx  = '0;
    row.val  = '0;
    row.smp  = '{range_mm: r, range_finite: fin, last_in_scan: last};
    row.lit  = lit;
    return row;
  endfunction

  function automatic plan_row_t wr(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] v);
    plan_row_t row;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.val  = v;
    row.smp  = '0;
    row.lit  = 1'b0;
    return row;
  endfunction

  function automatic logic [15:0] pick_range();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'(lo_mm);
      2: return 16'(hi_mm);
      3: return 16'(lo_mm - 1);
      4: return 16'(hi_mm + 1);
      5: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return (lo_mm <= hi_mm) ? 16'($urandom_range(hi_mm, lo_mm)) : 16'($urandom);
    endcase
  endfunction

  task automatic program_random_regs();
    logic [CfgDataW-1:0] v;
    case ($urandom_range(5))
      0: v = 17'd0;
      1: v = 17'hFFFF;
      2: v = 17'($urandom);
      default: v = 17'($urandom_range(600));
    endcase
    v[16] = 1'($urandom_range(1));
    write_reg(CFG_MIN_RANGE, v);
    case ($urandom_range(5))
      0: v = 17'hFFFF;
      1: v = 17'd0;
      2: v = 17'($urandom);
      default: v = 17'($urandom_range(65535, 3000));
    endcase
    v[16] = 1'($urandom_range(1));
    write_reg(CFG_MAX_RANGE, v);
    case ($urandom_range(6))
      0: v[15:0] = 16'(-18000);
      1: v[15:0] = 16'(17999);
      2: v[15:0] = 16'h8000;
      3: v[15:0] = 16'h7FFF;
      default: v[15:0] = 16'($urandom);
    endcase
    v[16] = 1'($urandom_range(1));
    write_reg(CFG_START_ANG, v);
    case ($urandom_range(9))
      0: v = 17'(-36000);
      1: v = 17'(36000);
      2: v = 17'h10000;
      3: v = 17'h0FFFF;
      4: v = 17'($urandom);
      default: v = 17'(int'($urandom_range(6000)) - 3000);
    endcase
    write_reg(CFG_ANG_STEP, v);
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(6))
        0: v = 17'd0;
        1: v = 17'd18000;
        2: v = 17'h7FFF;
        default: v = 17'($urandom_range(18000));
      endcase
      v[16:15] = 2'($urandom);
      write_reg((k == 0) ? CFG_FRONT_HALF : (k == 1) ? CFG_SIDE_HALF : CFG_REAR_HALF, v);
    end
  endtask

  task automatic random_scans(input int budget);
    int      sent;
    int      len;
    sample_t s;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(29) == 0) drain();
      len = ($urandom_range(9) == 0) ? 1 : int'($urandom_range(40, 2));
      for (int i = 0; i < len; i++) begin
        s.range_mm     = pick_range();
        s.range_finite = ($urandom_range(9) != 0);
        s.last_in_scan = (i == len - 1);
        deliver(s, 1'b0, LONE_INVALID);
      end
      sent += len;
    end
  endtask

  initial begin
    lo_mm    = 100;
    hi_mm    = 12000;
    start_cd = -18000;
    step_cd  = 50;
    hw_front = 1500;
    hw_side  = 2000;
    hw_rear  = 2000;
    clear_scan();

    // Directed stimulus
    plan.push_back(smp(16'd0, 1'b1, 1'b1, 1'b1));
    plan.push_back(smp(16'hFFFF, 1'b1, 1'b1, 1'b1));
    plan.push_back(smp(16'd500, 1'b0, 1'b1, 1'b1));
    plan.push_back(smp(16'd100, 1'b1, 1'b1, 1'b0));
    plan.push_back(smp(16'd12000, 1'b1, 1'b0, 1'b0));
    plan.push_back(smp(16'd12001, 1'b1, 1'b0, 1'b0));
    plan.push_back(smp(16'd99, 1'b1, 1'b1, 1'b0));
    plan.push_back(wr(CFG_MIN_RANGE, 17'd0));
    plan.push_back(wr(CFG_MAX_RANGE, 17'hFFFF));
    plan.push_back(smp(16'hFFFF, 1'b1, 1'b1, 1'b0));
    plan.push_back(wr(CFG_START_ANG, 17'd0));
    plan.push_back(wr(CFG_ANG_STEP, 17'd9000));
    plan.push_back(smp(16'd700, 1'b1, 1'b0, 1'b0));
    plan.push_back(smp(16'd300, 1'b1, 1'b0, 1'b0));
    plan.push_back(smp(16'hFFFF, 1'b1, 1'b0, 1'b0));
    plan.push_back(smp(16'd0, 1'b1, 1'b0, 1'b0));
    plan.push_back(smp(16'd300, 1'b1, 1'b1, 1'b0));
    plan.push_back(wr(CFG_FRONT_HALF, 17'd18000));
    plan.push_back(wr(CFG_SIDE_HALF, 17'd0));
    plan.push_back(wr(CFG_REAR_HALF, 17'h7FFF));
    plan.push_back(smp(16'd1000, 1'b1, 1'b0, 1'b0));
    // start angle moved mid-scan: applies from the next scan on
    plan.push_back(wr(CFG_START_ANG, 17'h08000));
    plan.push_back(smp(16'd1000, 1'b1, 1'b1, 1'b0));
    plan.push_back(smp(16'd5, 1'b1, 1'b1, 1'b0));
    plan.push_back(wr(CFG_ANG_STEP, 17'h10000));
    plan.push_back(wr(CFG_START_ANG, 17'h07FFF));
    plan.push_back(smp(16'd40, 1'b1, 1'b0, 1'b0));
    plan.push_back(smp(16'd41, 1'b1, 1'b1, 1'b0));
    plan.push_back(wr(CFG_ANG_STEP, 17'h0FFFF));
    plan.push_back(smp(16'd7, 1'b1, 1'b0, 1'b0));
    plan.push_back(smp(16'd7, 1'b1, 1'b1, 1'b0));
    plan.push_back(wr(CFG_MIN_RANGE, 17'd5000));
    plan.push_back(wr(CFG_MAX_RANGE, 17'd4000));
    plan.push_back(smp(16'd4500, 1'b1, 1'b1, 1'b1));
    plan.push_back(wr(CFG_UNUSED, 17'd0));
    plan.push_back(smp(16'd4000, 1'b1, 1'b1, 1'b1));
    plan.push_back(wr(CFG_MIN_RANGE, 17'd100));
    plan.push_back(wr(CFG_MAX_RANGE, 17'd12000));
    plan.push_back(wr(CFG_START_ANG, 17'(-18000)));
    plan.push_back(wr(CFG_ANG_STEP, 17'd50));
    plan.push_back(wr(CFG_FRONT_HALF, 17'd1500));
    plan.push_back(wr(CFG_SIDE_HALF, 17'd2000));
    plan.push_back(wr(CFG_REAR_HALF, 17'd2000));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        deliver(plan[i].smp, plan[i].lit, LONE_INVALID);
      end
    end

    for (int m = 0; m < 3; m++) begin
      src_idle_pct = (m == 0) ? 33 : (m == 1) ? 69 : 0;
      snk_idle_pct = (m == 0) ? 69 : (m == 1) ? 33 : 0;
      for (int g = 0; g < 3; g++) begin
        drain();
        program_random_regs();
        random_scans(160);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("PASS lidar_sector_min_range_core");
    end else begin
      $display("FAIL lidar_sector_min_range_core");
    end
    $finish;
  end

endmodule

// File: sim.f
design/lsmr_pkg.sv
design/lsmr_angle_gen.sv
design/lsmr_scan_acc.sv
design/lidar_sector_min_range_core.sv
tb/lidar_sector_min_range_core_tb.sv
